/* hdl/esl_pkg.sv */
`default_nettype none
package esl_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgW   = 32;

  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_TIMED = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_OFF   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_LIMIT_MODE    = 2'd0,
    CFG_WINDOW_LENGTH = 2'd1,
    CFG_EVENT_LIMIT   = 2'd2
  } cfg_idx_e;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

endpackage
`default_nettype wire

/* hdl/esl_in_if.sv */
`default_nettype none
interface esl_in_if
  import esl_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [1:0]             cmd;
  logic [TimeW-1:0]       time_now;

  modport source (output valid, output cmd, output time_now, input ready);
  modport sink   (input valid, input cmd, input time_now, output ready);
endinterface
`default_nettype wire

/* hdl/esl_out_if.sv */
`default_nettype none
interface esl_out_if
  import esl_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   suppressed;
  logic [CountW-1:0]      event_total;
  logic                   hold_active;

  modport source (output valid, output suppressed, output event_total, output hold_active,
                  input ready);
  modport sink   (input valid, input suppressed, input event_total, input hold_active,
                  output ready);
endinterface
`default_nettype wire

/* hdl/event_suppression_limiter.sv */
`default_nettype none
// event suppression limiter: one timestamped command in, one result out
//
// channels: in_i carries cmd (check, record, clear) and time_now; out_o carries
// suppressed, event_total and hold_active. both use valid/ready, a transfer
// happens at a rising edge with valid and ready high
// config: cfg_we_i/cfg_idx_i/cfg_wdata_i write limit_mode, window_length and
// event_limit; write only while no command is in flight
//
// an input transfer lands in the input register, then the result register
// drives out_o. throughput: one command per cycle while out_o is not
// stalled; the state update between the two registers is combinational
//
// reset: all state (active flag, count, window start, hold end), the config
// registers and both stage valids clear; the block is ready right after reset
// stall: a result held on out_o keeps its value; the input register still
// takes one more command, after that in_i.ready drops until out_o drains
module event_suppression_limiter
  import esl_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  esl_in_if.sink               in_i,
  esl_out_if.source            out_o
);

  // config registers
  logic [1:0]        mode_q;
  logic [TimeW-1:0]  wlen_q;
  logic [CountW-1:0] limit_q;

  // limiter state
  logic              act_q, act_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [TimeW-1:0]  begin_q, begin_d;
  logic [TimeW-1:0]  hold_q, hold_d;

  // input register
  logic              s1_valid_q;
  logic [1:0]        s1_cmd_q;
  logic [TimeW-1:0]  s1_time_q;

  // result register
  logic              s2_valid_q;
  logic              sup_q, sup_d;

  logic s2_adv, s1_adv;

  // result register frees up when empty or its result leaves this cycle
  assign s2_adv     = !s2_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && s2_adv;
  assign in_i.ready = !s1_valid_q || s2_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TIMED;
      wlen_q  <= '0;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LIMIT_MODE:    mode_q  <= cfg_wdata_i[1:0];
        CFG_WINDOW_LENGTH: wlen_q  <= cfg_wdata_i[TimeW-1:0];
        CFG_EVENT_LIMIT:   limit_q <= cfg_wdata_i[CountW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  function automatic mode_e s1_mode();
    unique case (mode_q)
      MODE_TIMED: s1_mode = MODE_TIMED;
      MODE_COUNT: s1_mode = MODE_COUNT;
      default:    s1_mode = MODE_OFF;
    endcase
  endfunction

  // next state and result for the command in the input register
  logic [TimeW-1:0]  elapsed;
  logic              roll;
  logic              act_r;
  logic [CountW-1:0] cnt_r, cnt_inc_r, cnt_inc;
  logic              before_hold;

  always_comb begin
    act_d   = act_q;
    cnt_d   = cnt_q;
    begin_d = begin_q;
    hold_d  = hold_q;
    sup_d   = 1'b0;

    // counted window restart, modulo 2^32 elapsed time
    elapsed     = s1_time_q - begin_q;
    roll        = elapsed > wlen_q;
    act_r       = roll ? 1'b0 : act_q;
    cnt_r       = roll ? '0 : cnt_q;
    cnt_inc_r   = (cnt_r == CountMax) ? cnt_r : cnt_r + 1'b1;
    cnt_inc     = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;
    before_hold = s1_time_q < hold_q;

    unique case (s1_cmd_q)
      CMD_CHECK: begin
        unique case (s1_mode())
          MODE_TIMED: begin
            if (act_q && before_hold) begin
              sup_d = 1'b1;
            end else if (act_q) begin
              // hold has run out; a check or a clear ends it, a record does not
              act_d = 1'b0;
              cnt_d = '0;
            end
          end
          MODE_COUNT: begin
            if (roll) begin
              begin_d = s1_time_q;
            end
            act_d = act_r;
            cnt_d = cnt_r;
            sup_d = act_r;
          end
          default: ;  // disabled and mode three never suppress
        endcase
      end
      CMD_RECORD: begin
        unique case (s1_mode())
          MODE_TIMED: begin
            if (!act_q) begin
              // first event opens the hold
              act_d  = 1'b1;
              hold_d = s1_time_q + wlen_q;
              cnt_d  = CountW'(1);
            end else begin
              cnt_d = cnt_inc;
              sup_d = before_hold;
            end
          end
          MODE_COUNT: begin
            if (roll) begin
              begin_d = s1_time_q;
            end
            cnt_d = cnt_inc_r;
            if (cnt_inc_r > limit_q) begin
              act_d = 1'b1;
              sup_d = 1'b1;
            end else begin
              act_d = act_r;
            end
          end
          default: ;
        endcase
      end
      CMD_CLEAR: begin
        act_d   = 1'b0;
        cnt_d   = '0;
        begin_d = '0;
        hold_d  = '0;
      end
      default: ;  // command three leaves state alone
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_cmd_q  <= in_i.cmd;
      s1_time_q <= in_i.time_now;
    end
  end

  // state and result register, updated as the command leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= 1'b0;
      cnt_q      <= '0;
      begin_q    <= '0;
      hold_q     <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        act_q   <= act_d;
        cnt_q   <= cnt_d;
        begin_q <= begin_d;
        hold_q  <= hold_d;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  logic [CountW-1:0] total_q;
  logic              hact_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      sup_q   <= sup_d;
      total_q <= cnt_d;
      hact_q  <= act_d;
    end
  end

  assign out_o.valid       = s2_valid_q;
  assign out_o.suppressed  = sup_q;
  assign out_o.event_total = total_q;
  assign out_o.hold_active = hact_q;

endmodule
`default_nettype wire

/* hdl/esl_checker.sv */
`default_nettype none
module esl_checker
  import esl_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic              out_suppressed_i,
  input wire logic              out_hold_active_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a suppressed result always comes with the active bit set
  a_sup_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_suppressed_i |-> out_hold_active_i)
    else $error("suppressed without active bit");

  // a command transfer shows a result after the input register and the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> ##1 out_valid_i)
    else $error("no result after command transfer");

endmodule

bind event_suppression_limiter esl_checker u_esl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_suppressed_i  (out_o.suppressed),
  .out_hold_active_i (out_o.hold_active)
);
`default_nettype wire
